@@ hw/rtl/hs_pkg.sv @@
// Shared types and constants of the heap sorter.
package hs_pkg;

  localparam int unsigned KEY_W = 16;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last_item;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             last_result;
    logic             overflow;
  } out_t;

  // Verdict of one sift-down step: move a child up, which one, and its key
  typedef struct packed {
    logic             move;
    logic             right;
    logic [KEY_W-1:0] value;
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIFT_LD,
    S_SIFT_CH,
    S_SIFT_CMP,
    S_EXT_RD,
    S_EXT_SW,
    S_OUT,
    S_LAST
  } state_e;

endpackage

@@ hw/rtl/heap_sorter.sv @@
// Heap sorter: loads keys one per transaction (start_i while busy_o is low) into a store
// of MAX_ITEMS entries, and on the key flagged last_item sorts the set with an in-place
// heap sort and emits it in ascending order, one key per cycle on res_o, strobed by
// res_valid_o; the receiver cannot stall, so every strobed result must be taken. Keys
// beyond capacity are dropped and every result of that set carries overflow. A key that
// does not close the set leaves busy_o low. The closing key of a set of two or more starts
// the sort, which runs over one key memory with two read ports and one write port and one
// shared compare unit: each sift-down first reads the key to sift, then compares it once per
// heap level it descends and once more where it stops. The output of the set follows the
// sort, and busy_o stays high for that whole time.
module heap_sorter
  import hs_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  in_t  item_i,
  output logic busy_o,
  output logic res_valid_o,
  output out_t res_o
);

  localparam int unsigned AW    = $clog2(MAX_ITEMS);
  localparam int unsigned CW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned XW    = AW + 2;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            drop_q, drop_d;
  logic [CW-1:0]   len_q, len_d;
  logic [AW-1:0]   node_q, node_d;
  logic [AW-1:0]   k_q, k_d;
  logic            extract_q, extract_d;
  logic [KEY_W-1:0] v_q, v_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wdata;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [KEY_W-1:0] rdata_a;
  logic [KEY_W-1:0] rdata_b;

  logic [XW-1:0]    lc_cur;
  logic [XW-1:0]    rc_cur;
  logic [XW-1:0]    lc_nxt;
  logic [XW-1:0]    rc_nxt;
  logic [XW-1:0]    len_x;
  cmp_res_t         cmp;
  logic             full;
  logic [CW-1:0]    n_new;
  logic [CW-1:0]    half_m1;
  logic [CW-1:0]    len_m1;

  hs_ram #(
    .DEPTH (DEPTH),
    .W     (KEY_W),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign lc_cur = XW'({node_q, 1'b0}) + XW'(1);
  assign rc_cur = XW'({node_q, 1'b0}) + XW'(2);
  assign lc_nxt = XW'({node_d, 1'b0}) + XW'(1);
  assign rc_nxt = XW'({node_d, 1'b0}) + XW'(2);
  assign len_x  = XW'(len_q);

  hs_cmp u_cmp (
    .parent_i   (v_q),
    .left_i     (rdata_a),
    .right_i    (rdata_b),
    .left_ok_i  (lc_cur < len_x),
    .right_ok_i (rc_cur < len_x),
    .res_o      (cmp)
  );

  assign full    = (cnt_q == CW'(MAX_ITEMS));
  assign n_new   = full ? cnt_q : cnt_q + CW'(1);
  assign half_m1 = (n_new >> 1) - CW'(1);
  assign len_m1  = len_q - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    node_q    <= node_d;
    k_q       <= k_d;
    extract_q <= extract_d;
    v_q       <= v_d;
    idx_q     <= idx_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    len_d       = len_q;
    node_d      = node_q;
    k_d         = k_q;
    extract_d   = extract_q;
    v_d         = v_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    pend_last_d = 1'b0;
    we          = 1'b0;
    waddr       = node_q;
    wdata       = v_q;
    raddr_a     = lc_nxt[AW-1:0];
    raddr_b     = rc_nxt[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = cnt_q[AW-1:0];
            wdata = item_i.key;
            cnt_d = cnt_q + CW'(1);
          end
          if (item_i.last_item) begin
            idx_d = '0;
            if (n_new > CW'(1)) begin
              len_d     = n_new;
              k_d       = half_m1[AW-1:0];
              node_d    = half_m1[AW-1:0];
              extract_d = 1'b0;
              state_d   = S_SIFT_LD;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end

      S_SIFT_LD: begin
        raddr_a = node_q;
        state_d = S_SIFT_CH;
      end

      S_SIFT_CH: begin
        // capture the key being sifted; children reads go out now
        v_d     = rdata_a;
        state_d = S_SIFT_CMP;
      end

      S_SIFT_CMP: begin
        we = 1'b1;
        if (cmp.move) begin
          // promote the larger child and descend
          wdata  = cmp.value;
          node_d = cmp.right ? rc_cur[AW-1:0] : lc_cur[AW-1:0];
        end else begin
          wdata = v_q;
          if (!extract_q) begin
            if (k_q == '0) begin
              extract_d = 1'b1;
              state_d   = S_EXT_RD;
            end else begin
              k_d     = k_q - AW'(1);
              node_d  = k_q - AW'(1);
              state_d = S_SIFT_LD;
            end
          end else if (len_q == CW'(1)) begin
            idx_d   = '0;
            state_d = S_OUT;
          end else begin
            state_d = S_EXT_RD;
          end
        end
      end

      S_EXT_RD: begin
        raddr_a = '0;
        raddr_b = len_m1[AW-1:0];
        state_d = S_EXT_SW;
      end

      S_EXT_SW: begin
        // move the root to the end of the heap, sift the old end from the root
        we      = 1'b1;
        waddr   = len_m1[AW-1:0];
        wdata   = rdata_a;
        v_d     = rdata_b;
        len_d   = len_m1;
        node_d  = '0;
        state_d = S_SIFT_CMP;
      end

      S_OUT: begin
        raddr_a = idx_q;
        pend_d  = 1'b1;
        idx_d   = idx_q + AW'(1);
        if (CW'(idx_q) + CW'(1) == cnt_q) begin
          pend_last_d = 1'b1;
          state_d     = S_LAST;
        end
      end

      S_LAST: begin
        cnt_d   = '0;
        drop_d  = 1'b0;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o            = (state_q != S_IDLE);
  assign res_valid_o       = pend_q;
  assign res_o.sorted_key  = rdata_a;
  assign res_o.last_result = pend_last_q;
  assign res_o.overflow    = drop_q;

endmodule

@@ hw/rtl/hs_ram.sv @@
// Key store: one write port, two registered read ports.
module hs_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned W     = 16,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [W-1:0]  rdata_a_o,
  output logic [W-1:0]  rdata_b_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ hw/rtl/hs_cmp.sv @@
// Sift-down compare unit: picks the largest of a parent key and its two children.
module hs_cmp
  import hs_pkg::*;
(
  input  logic [KEY_W-1:0] parent_i,
  input  logic [KEY_W-1:0] left_i,
  input  logic [KEY_W-1:0] right_i,
  input  logic             left_ok_i,
  input  logic             right_ok_i,
  output cmp_res_t         res_o
);

  logic             take_l;
  logic             take_r;
  logic [KEY_W-1:0] big;

  always_comb begin
    take_l = left_ok_i && (left_i > parent_i);
    big    = take_l ? left_i : parent_i;
    // right child wins only if strictly larger than the current largest
    take_r = right_ok_i && (right_i > big);
    res_o.move  = take_l | take_r;
    res_o.right = take_r;
    res_o.value = take_r ? right_i : big;
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the heap sorter: key sets in, ascending results checked.
module tb_top;
  import hs_pkg::*;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IN_W = $bits(in_t);

  // Predicts the sorted sets and checks each strobed result against the oldest one
  class sort_scoreboard;
    logic [KEY_W-1:0] held_keys[$];  // keys of the open set, kept ascending
    bit               dropped;
    out_t             sorted_q[$];
    int unsigned      capacity;
    int unsigned      mismatches;
    int unsigned      sets_closed;
    int unsigned      keys_held;
    int unsigned      results_seen;
    int unsigned      overflow_sets;

    function new(int unsigned cap);
      capacity = cap;
      dropped = 1'b0;
      mismatches = 0;
      sets_closed = 0;
      keys_held = 0;
      results_seen = 0;
      overflow_sets = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void note_key(in_t it);
      int unsigned pos;
      out_t        want;
      if (held_keys.size() < capacity) begin
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] <= it.key) pos++;
        held_keys.insert(pos, it.key);
        keys_held++;
      end else begin
        dropped = 1'b1;
      end
      if (it.last_item) begin
        foreach (held_keys[k]) begin
          want.sorted_key  = held_keys[k];
          want.last_result = (k == held_keys.size() - 1);
          want.overflow    = dropped;
          sorted_q.push_back(want);
        end
        sets_closed++;
        if (dropped) overflow_sets++;
        held_keys.delete();
        dropped = 1'b0;
      end
    endfunction

    task check_result(out_t got);
      out_t want;
      results_seen++;
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", got.sorted_key));
        return;
      end
      want = sorted_q.pop_front();
      if (got.sorted_key !== want.sorted_key)
        report_mismatch($sformatf("sorted_key %h, expected %h",
                                  got.sorted_key, want.sorted_key));
      if (got.last_result !== want.last_result)
        report_mismatch($sformatf("last_result %b, expected %b on key %h",
                                  got.last_result, want.last_result, want.sorted_key));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %b, expected %b on key %h",
                                  got.overflow, want.overflow, want.sorted_key));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  in_t  item_i;
  logic busy_o;
  logic res_valid_o;
  out_t res_o;

  sort_scoreboard sb;
  int unsigned    cycle_count;
  int unsigned    random_keys;

  heap_sorter #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) sb.check_result(res_o);
  end

  // Drop start and hold it low, with noise on the item fields, for the length given by n
  task automatic idle(input int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    start_i <= 1'b0;
    item_i  <= in_t'(IN_W'($urandom));
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Present one key and hold it until the transaction completes
  task automatic send_key(input logic [KEY_W-1:0] k, input logic l);
    in_t it;
    it.key       = k;
    it.last_item = l;
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_key(it);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return KEY_W'($urandom_range(3));  // force equal keys
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned n);
    bit burst;
    burst = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      if (!burst) idle(pick_gap());
      send_key(pick_key(), i == n - 1);
    end
  endtask

  initial begin
    int unsigned n;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cycle_count = 0;
    random_keys = 0;
    sb = new(MAX_ITEMS);
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single-key sets at both extremes, then a two-key set in reverse order
    send_key('0, 1'b1);
    send_key('1, 1'b1);
    send_key('1, 1'b0);
    send_key('0, 1'b1);
    // All keys equal
    for (int i = 0; i < 4; i++) send_key(16'h0007, i == 3);
    idle(pick_gap());
    // Descending run, then walking ones
    for (int i = 0; i < 8; i++) send_key(16'hFFFF >> i, i == 7);
    for (int i = 0; i < 5; i++) begin
      idle(pick_gap());
      send_key(16'h0001 << (3 * i), i == 4);
    end

    while (random_keys < 10) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      send_set(n);
      random_keys += n;
    end
    // Fill the store past capacity, the closing key dropped, then a small set
    send_set(MAX_ITEMS + $urandom_range(1, 4));
    send_set($urandom_range(1, 6));

    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.sorted_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("ran %0d key sets (%0d with dropped keys), %0d keys held, %0d results checked",
             sb.sets_closed, sb.overflow_sets, sb.keys_held, sb.results_seen);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
